// ===== rtl/cartridge_bank_mapper_83_unit_macros.svh =====
// Assertion macros shared by the mapper RTL.
`ifndef CARTRIDGE_BANK_MAPPER_83_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_83_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CBM83_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CBM83_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbm83_pkg.sv =====
// Types and constants for the cartridge bank mapper.
package cbm83_pkg;

    // Request function codes
    localparam logic [2:0] FUNC_CPU_WRITE = 3'd0;
    localparam logic [2:0] FUNC_CPU_READ  = 3'd1;
    localparam logic [2:0] FUNC_PPU_FETCH = 3'd2;
    localparam logic [2:0] FUNC_TICK      = 3'd3;
    localparam logic [2:0] FUNC_RESET_BTN = 3'd4;

    // Response target codes
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_PRG  = 2'd1;
    localparam logic [1:0] TGT_WRAM = 2'd2;
    localparam logic [1:0] TGT_CHR  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PRG_MASK = 1'b0;
    localparam logic CFG_CHR_MASK = 1'b1;

    // Mapper register addresses
    localparam logic [15:0] ADDR_DIP       = 16'h5000;
    localparam logic [15:0] ADDR_SCRATCH   = 16'h5100;
    localparam logic [15:0] ADDR_WRAM_LO   = 16'h6000;
    localparam logic [15:0] ADDR_ROM_LO    = 16'h8000;
    localparam logic [15:0] ADDR_BANK      = 16'h8000;
    localparam logic [15:0] ADDR_BANK_B000 = 16'hB000;
    localparam logic [15:0] ADDR_BANK_B0FF = 16'hB0FF;
    localparam logic [15:0] ADDR_BANK_B1FF = 16'hB1FF;
    localparam logic [15:0] ADDR_MODE      = 16'h8100;
    localparam logic [15:0] ADDR_IRQ_LO    = 16'h8200;
    localparam logic [15:0] ADDR_IRQ_HI    = 16'h8201;
    localparam logic [15:0] ADDR_PRG0      = 16'h8300;
    localparam logic [15:0] ADDR_PRG1      = 16'h8301;
    localparam logic [15:0] ADDR_PRG2      = 16'h8302;
    localparam logic [15:0] ADDR_CHR0      = 16'h8310;
    localparam logic [15:0] ADDR_CHR1      = 16'h8311;
    localparam logic [15:0] ADDR_CHR2      = 16'h8312;
    localparam logic [15:0] ADDR_CHR3      = 16'h8313;
    localparam logic [15:0] ADDR_CHR4      = 16'h8314;
    localparam logic [15:0] ADDR_CHR5      = 16'h8315;
    localparam logic [15:0] ADDR_CHR6      = 16'h8316;
    localparam logic [15:0] ADDR_CHR7      = 16'h8317;

    localparam int NUM_BANK_REGS = 11;
    localparam int NUM_SCRATCH   = 4;

    localparam logic [7:0] PRG_MASK_RESET = 8'hFF;
    localparam logic [9:0] CHR_MASK_RESET = 10'h3FF;
    localparam logic [15:0] IRQ_RELOAD    = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  open_bus;
        logic [7:0]  cycles;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_valid;
        logic [1:0]  target;
        logic [20:0] mapped_address;
        logic [1:0]  mirroring;
        logic        irq;
    } rsp_t;

    // Current register view consumed by the translator
    typedef struct packed {
        logic [7:0]                          mode;
        logic [7:0]                          bank;
        logic [NUM_BANK_REGS-1:0][7:0]       banks;
        logic [NUM_SCRATCH-1:0][7:0]         scratch;
        logic                                dip;
        logic                                two_k_seen;
        logic                                one_k_seen;
        logic [7:0]                          prg_mask;
        logic [9:0]                          chr_mask;
    } map_view_t;

    // Post-update status reported with each response
    typedef struct packed {
        logic [1:0] mirroring;
        logic       irq;
    } map_status_t;

endpackage

// ===== rtl/cbm83_regs.sv =====
// Mapper register file: write decode, IRQ counter and configuration masks.
module cbm83_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  cbm83_pkg::req_t        item,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [9:0]             cfg_data,
    output cbm83_pkg::map_view_t   view,
    output cbm83_pkg::map_status_t status
);

    logic [7:0]                                    mode_reg, mode_next;
    logic [7:0]                                    bank_reg, bank_next;
    logic [cbm83_pkg::NUM_BANK_REGS-1:0][7:0]      banks_reg, banks_next;
    logic [cbm83_pkg::NUM_SCRATCH-1:0][7:0]        scratch_reg, scratch_next;
    logic                                          dip_reg, dip_next;
    logic                                          irq_en_reg, irq_en_next;
    logic [15:0]                                   irq_cnt_reg, irq_cnt_next;
    logic                                          irq_line_reg, irq_line_next;
    logic                                          two_k_reg, two_k_next;
    logic                                          one_k_reg, one_k_next;
    logic [7:0]                                    prg_mask_reg, prg_mask_next;
    logic [9:0]                                    chr_mask_reg, chr_mask_next;
    logic [15:0]                                   tick_cycles;

    assign tick_cycles = {8'd0, item.cycles};

    always_comb
    begin
        mode_next     = mode_reg;
        bank_next     = bank_reg;
        banks_next    = banks_reg;
        scratch_next  = scratch_reg;
        dip_next      = dip_reg;
        irq_en_next   = irq_en_reg;
        irq_cnt_next  = irq_cnt_reg;
        irq_line_next = irq_line_reg;
        two_k_next    = two_k_reg;
        one_k_next    = one_k_reg;
        prg_mask_next = prg_mask_reg;
        chr_mask_next = chr_mask_reg;

        if (fire)
        begin
            unique case (item.func)
                cbm83_pkg::FUNC_CPU_WRITE:
                begin
                    if (item.address[15:2] == cbm83_pkg::ADDR_SCRATCH[15:2])
                    begin
                        scratch_next[item.address[1:0]] = item.data;
                    end
                    else
                    begin
                        unique case (item.address)
                            cbm83_pkg::ADDR_BANK:
                            begin
                                two_k_next   = 1'b1;
                                bank_next    = item.data;
                                mode_next[6] = 1'b1;
                            end
                            cbm83_pkg::ADDR_BANK_B000,
                            cbm83_pkg::ADDR_BANK_B0FF,
                            cbm83_pkg::ADDR_BANK_B1FF:
                            begin
                                bank_next    = item.data;
                                mode_next[6] = 1'b1;
                            end
                            cbm83_pkg::ADDR_MODE:
                            begin
                                // 16K mode bit survives a mode write; the data can only set it
                                mode_next = {item.data[7], item.data[6] | mode_reg[6],
                                             item.data[5:0]};
                            end
                            cbm83_pkg::ADDR_IRQ_LO:
                            begin
                                irq_cnt_next[7:0] = item.data;
                                irq_line_next     = 1'b0;
                            end
                            cbm83_pkg::ADDR_IRQ_HI:
                            begin
                                irq_en_next        = mode_reg[7];
                                irq_cnt_next[15:8] = item.data;
                            end
                            cbm83_pkg::ADDR_PRG0,
                            cbm83_pkg::ADDR_PRG1,
                            cbm83_pkg::ADDR_PRG2:
                            begin
                                banks_next[{2'b10, item.address[1:0]}] = item.data;
                                mode_next[6] = 1'b0;
                            end
                            cbm83_pkg::ADDR_CHR0,
                            cbm83_pkg::ADDR_CHR1,
                            cbm83_pkg::ADDR_CHR6,
                            cbm83_pkg::ADDR_CHR7:
                            begin
                                banks_next[{1'b0, item.address[2:0]}] = item.data;
                            end
                            cbm83_pkg::ADDR_CHR2,
                            cbm83_pkg::ADDR_CHR3,
                            cbm83_pkg::ADDR_CHR4,
                            cbm83_pkg::ADDR_CHR5:
                            begin
                                banks_next[{1'b0, item.address[2:0]}] = item.data;
                                one_k_next = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                cbm83_pkg::FUNC_TICK:
                begin
                    if (irq_en_reg)
                    begin
                        // underflow fires, hitting zero exactly does not
                        if (tick_cycles > irq_cnt_reg)
                        begin
                            irq_line_next = 1'b1;
                            irq_en_next   = 1'b0;
                            irq_cnt_next  = cbm83_pkg::IRQ_RELOAD;
                        end
                        else
                        begin
                            irq_cnt_next = irq_cnt_reg - tick_cycles;
                        end
                    end
                end
                cbm83_pkg::FUNC_RESET_BTN:
                begin
                    dip_next = ~dip_reg;
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                cbm83_pkg::CFG_PRG_MASK: prg_mask_next = cfg_data[7:0];
                cbm83_pkg::CFG_CHR_MASK: chr_mask_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            bank_reg     <= '0;
            banks_reg    <= '0;
            scratch_reg  <= '0;
            dip_reg      <= 1'b0;
            irq_en_reg   <= 1'b0;
            irq_cnt_reg  <= '0;
            irq_line_reg <= 1'b0;
            two_k_reg    <= 1'b0;
            one_k_reg    <= 1'b0;
            prg_mask_reg <= cbm83_pkg::PRG_MASK_RESET;
            chr_mask_reg <= cbm83_pkg::CHR_MASK_RESET;
        end
        else
        begin
            mode_reg     <= mode_next;
            bank_reg     <= bank_next;
            banks_reg    <= banks_next;
            scratch_reg  <= scratch_next;
            dip_reg      <= dip_next;
            irq_en_reg   <= irq_en_next;
            irq_cnt_reg  <= irq_cnt_next;
            irq_line_reg <= irq_line_next;
            two_k_reg    <= two_k_next;
            one_k_reg    <= one_k_next;
            prg_mask_reg <= prg_mask_next;
            chr_mask_reg <= chr_mask_next;
        end
    end

    always_comb
    begin
        view.mode       = mode_reg;
        view.bank       = bank_reg;
        view.banks      = banks_reg;
        view.scratch    = scratch_reg;
        view.dip        = dip_reg;
        view.two_k_seen = two_k_reg;
        view.one_k_seen = one_k_reg;
        view.prg_mask   = prg_mask_reg;
        view.chr_mask   = chr_mask_reg;
        status.mirroring = mode_next[1:0];
        status.irq       = irq_line_next;
    end

endmodule

// ===== rtl/cbm83_xlate.sv =====
// Address translation and register read-back for one request.
module cbm83_xlate #(
    parameter int PRG_ADDR_BITS = 21,
    parameter int CHR_ADDR_BITS = 20
) (
    input  cbm83_pkg::req_t      item,
    input  cbm83_pkg::map_view_t view,
    output logic [7:0]           read_data,
    output logic                 read_valid,
    output logic [1:0]           target,
    output logic [20:0]          mapped_address
);

    localparam logic [20:0] PRG_WIN = 21'((64'd1 << PRG_ADDR_BITS) - 64'd1);
    localparam logic [19:0] CHR_WIN = 20'((64'd1 << CHR_ADDR_BITS) - 64'd1);

    logic [1:0]  prg_slot;
    logic [2:0]  chr_slot;
    logic        chr_2k;
    logic [3:0]  bank_idx;
    logic [7:0]  bank_val;
    logic [5:0]  prg_b16;
    logic [7:0]  prg_b8;
    logic [9:0]  chr_b1;
    logic [20:0] prg_addr;
    logic [20:0] chr_addr;
    logic [20:0] wram_addr;

    assign prg_slot = item.address[14:13];
    assign chr_slot = item.address[12:10];
    assign chr_2k   = view.two_k_seen && !view.one_k_seen;

    // One bank register read per request: PRG slots for cpu reads, CHR otherwise
    always_comb
    begin
        if (item.func == cbm83_pkg::FUNC_CPU_READ)
        begin
            bank_idx = {2'b10, prg_slot};
        end
        else if (chr_2k)
        begin
            // 2K pages map to registers 0, 1, 6, 7
            bank_idx = {1'b0, chr_slot[2], chr_slot[2], chr_slot[1]};
        end
        else
        begin
            bank_idx = {1'b0, chr_slot};
        end
        bank_val = (bank_idx < 4'(cbm83_pkg::NUM_BANK_REGS)) ? view.banks[bank_idx] : 8'd0;
    end

    always_comb
    begin
        prg_b16 = prg_slot[1] ? {view.bank[5:4], 4'hF} : view.bank[5:0];
        if (view.mode[6])
        begin
            prg_b8 = {1'b0, prg_b16, prg_slot[0]};
        end
        else
        begin
            prg_b8 = (prg_slot == 2'd3) ? 8'hFF : bank_val;
        end
        prg_b8   = prg_b8 & view.prg_mask;
        prg_addr = {prg_b8, item.address[12:0]} & PRG_WIN;

        if (chr_2k)
        begin
            chr_b1 = {1'b0, bank_val, chr_slot[0]};
        end
        else
        begin
            chr_b1 = {view.bank[5:4], bank_val};
        end
        chr_b1   = chr_b1 & view.chr_mask;
        chr_addr = {1'b0, {chr_b1, item.address[9:0]} & CHR_WIN};

        wram_addr = {8'd0, item.address[12:0]};
    end

    always_comb
    begin
        read_data      = 8'd0;
        read_valid     = 1'b0;
        target         = cbm83_pkg::TGT_NONE;
        mapped_address = 21'd0;
        unique case (item.func)
            cbm83_pkg::FUNC_CPU_WRITE:
            begin
                if (item.address[15:13] == cbm83_pkg::ADDR_WRAM_LO[15:13])
                begin
                    target         = cbm83_pkg::TGT_WRAM;
                    mapped_address = wram_addr;
                end
            end
            cbm83_pkg::FUNC_CPU_READ:
            begin
                priority if (item.address == cbm83_pkg::ADDR_DIP)
                begin
                    read_data  = {item.open_bus[7:2], 1'b0, view.dip};
                    read_valid = 1'b1;
                end
                else if (item.address[15:2] == cbm83_pkg::ADDR_SCRATCH[15:2])
                begin
                    read_data  = view.scratch[item.address[1:0]];
                    read_valid = 1'b1;
                end
                else if (item.address[15:13] == cbm83_pkg::ADDR_WRAM_LO[15:13])
                begin
                    target         = cbm83_pkg::TGT_WRAM;
                    mapped_address = wram_addr;
                end
                else if (item.address[15] == cbm83_pkg::ADDR_ROM_LO[15])
                begin
                    target         = cbm83_pkg::TGT_PRG;
                    mapped_address = prg_addr;
                end
                else
                begin
                end
            end
            cbm83_pkg::FUNC_PPU_FETCH:
            begin
                if (item.address[15:13] == 3'd0)
                begin
                    target         = cbm83_pkg::TGT_CHR;
                    mapped_address = chr_addr;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/cartridge_bank_mapper_83_unit.sv =====
// Top level of the cartridge bank mapper: request and response stages.
//
// Usage
//   req channel:  one bus event per transfer (cpu write/read, ppu pattern fetch,
//                 counter tick, reset button). req_ready is high whenever the
//                 request stage is empty or moving on this cycle.
//   rsp channel:  exactly one response per request, in order: read-back byte,
//                 target memory and byte address, mirroring and IRQ level as
//                 they stand after that request's register update.
//   cfg channel:  writes the PRG/CHR bank masks; always ready. Write only while
//                 no request is in flight.
// Path: an accepted request goes into the request register, is translated, and its
//   response is loaded into the response register; rsp_valid is high from then
//   on until that response transfers.
// Throughput: one transfer per cycle while rsp_ready is high. A new request is
//   taken while a finished response waits only if the request stage is empty.
// Stall: when rsp_ready is low and the response register is full, the request
//   stage holds its item and req_ready drops until the response moves.
// Reset: rst_n clears all mapper registers, IRQ state and both stages; the
//   masks return to all ones.
`include "cartridge_bank_mapper_83_unit_macros.svh"

module cartridge_bank_mapper_83_unit #(
    parameter int PRG_ADDR_BITS = 21,
    parameter int CHR_ADDR_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cbm83_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cbm83_pkg::rsp_t   rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [9:0]        cfg_data
);

    logic                   in_valid_reg, in_valid_next;
    cbm83_pkg::req_t        in_item_reg;
    logic                   out_valid_reg, out_valid_next;
    cbm83_pkg::rsp_t        out_item_reg, out_item_next;
    logic                   req_accept;
    logic                   fire;   // request stage hands its item to the response stage
    cbm83_pkg::map_view_t   view;
    cbm83_pkg::map_status_t status;
    logic [7:0]             x_read_data;
    logic                   x_read_valid;
    logic [1:0]             x_target;
    logic [20:0]            x_mapped_address;

    assign fire       = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready  = !in_valid_reg || fire;
    assign req_accept = req_valid && req_ready;
    assign cfg_ready  = 1'b1;

    // Register state; updated by the item leaving the request stage and by cfg writes
    cbm83_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (view),
        .status    (status)
    );

    // Translation uses the registers as they were before this item
    cbm83_xlate #(
        .PRG_ADDR_BITS (PRG_ADDR_BITS),
        .CHR_ADDR_BITS (CHR_ADDR_BITS)
    ) u_xlate (
        .item           (in_item_reg),
        .view           (view),
        .read_data      (x_read_data),
        .read_valid     (x_read_valid),
        .target         (x_target),
        .mapped_address (x_mapped_address)
    );

    always_comb
    begin
        out_item_next.read_data      = x_read_data;
        out_item_next.read_valid     = x_read_valid;
        out_item_next.target         = x_target;
        out_item_next.mapped_address = x_mapped_address;
        out_item_next.mirroring      = status.mirroring;
        out_item_next.irq            = status.irq;

        priority if (req_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        priority if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            in_item_reg <= req;
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    `CBM83_ASSERT_IMP(a_rd_no_target, rsp_valid && rsp.read_valid, rsp.target == cbm83_pkg::TGT_NONE, "read-back response also selects a memory")
    `CBM83_ASSERT_IMP(a_rd_data_zero, rsp_valid && !rsp.read_valid, rsp.read_data == 8'd0, "read_data nonzero without read_valid")
    `CBM83_ASSERT_IMP(a_addr_zero, rsp_valid && (rsp.target == cbm83_pkg::TGT_NONE), rsp.mapped_address == 21'd0, "address nonzero with no target")
    `CBM83_ASSERT_NXT(a_req_loaded, req_accept, in_valid_reg, "accepted request not held in request stage")
    `CBM83_ASSERT_NXT(a_req_held, in_valid_reg && !fire, in_valid_reg && $stable(in_item_reg), "stalled request stage lost its item")

endmodule
